// ===== sv/morton_cell_point_grouper_unit_assert.svh =====
`ifndef MORTON_CELL_POINT_GROUPER_UNIT_ASSERT_SVH
`define MORTON_CELL_POINT_GROUPER_UNIT_ASSERT_SVH

// same-cycle implication
`define MCPG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MCPG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/mcpg_pkg.sv =====
package mcpg_pkg;

   localparam int unsigned COUNT_WIDTH     = 24;
   localparam int unsigned COORD_WIDTH     = 32;
   localparam int unsigned CELL_PIXEL_LOG2 = 5;
   localparam int unsigned TILE_PIXEL_LOG2 = 8;
   localparam int unsigned ZOOM_WIDTH      = 5;
   localparam int unsigned CODE_WIDTH      = 2 * COORD_WIDTH;
   localparam int unsigned SUM_WIDTH       = COORD_WIDTH + COUNT_WIDTH;
   localparam int unsigned CELL_LOG2_BASE  =
      COORD_WIDTH - (TILE_PIXEL_LOG2 - CELL_PIXEL_LOG2);
   localparam int unsigned CL_WIDTH        = $clog2(CELL_LOG2_BASE + 1);
   localparam int unsigned SHIFT_WIDTH     = CL_WIDTH + 1;
   localparam int unsigned STEP_WIDTH      = $clog2(SUM_WIDTH);
   localparam int unsigned QUEUE_DEPTH     = 4;
   localparam int unsigned QPTR_WIDTH      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_WIDTH      = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VIEW_MIN   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VIEW_MAX   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ZOOM_LEVEL = 2'd2;

   typedef struct packed {
      logic [SUM_WIDTH-1:0]   x_total;
      logic [SUM_WIDTH-1:0]   y_total;
      logic [COUNT_WIDTH-1:0] count;
      logic                   end_of_groups;
   } grp_rec_type;

   typedef struct packed {
      logic first;
      logic second;
   } grp_push_type;

   typedef struct packed {
      logic has_item;
      logic has_room;
   } que_stat_type;

   function automatic logic [COORD_WIDTH-1:0] deinterleave(
      input logic [CODE_WIDTH-1:0] code,
      input logic                  odd
   );
      logic [COORD_WIDTH-1:0] v;
      v = '0;
      for (int i = 0; i < COORD_WIDTH; i++) begin
         v[i] = odd ? code[2*i+1] : code[2*i];
      end
      return v;
   endfunction

   function automatic logic [CODE_WIDTH-1:0] interleave(
      input logic [COORD_WIDTH-1:0] x,
      input logic [COORD_WIDTH-1:0] y
   );
      logic [CODE_WIDTH-1:0] c;
      c = '0;
      for (int i = 0; i < COORD_WIDTH; i++) begin
         c[2*i]   = x[i];
         c[2*i+1] = y[i];
      end
      return c;
   endfunction

endpackage

// ===== sv/mcpg_front.sv =====
module mcpg_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic [mcpg_pkg::CODE_WIDTH-1:0]        req_code,
   input  logic                                   req_last,
   input  logic                                   csr_we,
   input  logic [mcpg_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [mcpg_pkg::CODE_WIDTH-1:0]        csr_wdata,
   input  mcpg_pkg::que_stat_type                 que_stat,
   output mcpg_pkg::grp_push_type                 grp_push,
   output mcpg_pkg::grp_rec_type                  rec_first,
   output mcpg_pkg::grp_rec_type                  rec_second
);

   logic [mcpg_pkg::CODE_WIDTH-1:0]  view_min_ff, view_min_in;
   logic [mcpg_pkg::CODE_WIDTH-1:0]  view_max_ff, view_max_in;
   logic [mcpg_pkg::ZOOM_WIDTH-1:0]  zoom_ff, zoom_in;
   logic                             open_ff, open_in;
   logic [mcpg_pkg::CODE_WIDTH:0]    cell_end_ff, cell_end_in;
   logic [mcpg_pkg::SUM_WIDTH-1:0]   x_total_ff, x_total_in;
   logic [mcpg_pkg::SUM_WIDTH-1:0]   y_total_ff, y_total_in;
   logic [mcpg_pkg::COUNT_WIDTH-1:0] count_ff, count_in;

   logic                             accept;
   logic [mcpg_pkg::COORD_WIDTH-1:0] code_x, code_y, x0, y0, x1, y1;
   logic                             in_view, in_rect, joins, closes, opens, flush;
   logic [mcpg_pkg::CL_WIDTH-1:0]    cl;
   logic [mcpg_pkg::SHIFT_WIDTH-1:0] shift;
   logic [mcpg_pkg::CODE_WIDTH-1:0]  base_keep;
   logic [mcpg_pkg::CODE_WIDTH:0]    new_end;
   logic                             a_open;
   mcpg_pkg::grp_rec_type            close_rec, flush_rec;

   assign req_full = !que_stat.has_room;
   assign accept   = req_push && !req_full;

   always_comb begin
      code_x = mcpg_pkg::deinterleave(req_code, 1'b0);
      code_y = mcpg_pkg::deinterleave(req_code, 1'b1);
      x0     = mcpg_pkg::deinterleave(view_min_ff, 1'b0);
      y0     = mcpg_pkg::deinterleave(view_min_ff, 1'b1);
      x1     = mcpg_pkg::deinterleave(view_max_ff, 1'b0);
      y1     = mcpg_pkg::deinterleave(view_max_ff, 1'b1);

      in_view = (req_code >= view_min_ff) && (req_code <= view_max_ff);
      in_rect = (code_x >= x0) && (code_x <= x1) && (code_y >= y0) && (code_y <= y1);
      joins   = in_view && open_ff && ({1'b0, req_code} < cell_end_ff);
      closes  = in_view && open_ff && !joins;
      opens   = in_view && !joins && in_rect;

      // cell size from zoom, clamped at one code
      if (zoom_ff > mcpg_pkg::ZOOM_WIDTH'(mcpg_pkg::CELL_LOG2_BASE)) begin
         cl = '0;
      end else begin
         cl = mcpg_pkg::CL_WIDTH'(mcpg_pkg::CELL_LOG2_BASE) - mcpg_pkg::CL_WIDTH'(zoom_ff);
      end
      shift     = {cl, 1'b0};
      base_keep = {mcpg_pkg::CODE_WIDTH{1'b1}} << shift;
      new_end   = {1'b0, req_code & base_keep}
                + ((mcpg_pkg::CODE_WIDTH + 1)'(1) << shift);

      close_rec.x_total       = x_total_ff;
      close_rec.y_total       = y_total_ff;
      close_rec.count         = count_ff;
      close_rec.end_of_groups = 1'b0;

      a_open      = open_ff;
      cell_end_in = cell_end_ff;
      x_total_in  = x_total_ff;
      y_total_in  = y_total_ff;
      count_in    = count_ff;
      if (accept && in_view) begin
         if (joins) begin
            if (count_ff != mcpg_pkg::COUNT_MAX) begin
               x_total_in = x_total_ff + mcpg_pkg::SUM_WIDTH'(code_x);
               y_total_in = y_total_ff + mcpg_pkg::SUM_WIDTH'(code_y);
               count_in   = count_ff + mcpg_pkg::COUNT_WIDTH'(1);
            end
         end else begin
            a_open = opens;
            if (opens) begin
               cell_end_in = new_end;
               x_total_in  = mcpg_pkg::SUM_WIDTH'(code_x);
               y_total_in  = mcpg_pkg::SUM_WIDTH'(code_y);
               count_in    = mcpg_pkg::COUNT_WIDTH'(1);
            end
         end
      end

      flush                   = accept && req_last && a_open;
      flush_rec.x_total       = x_total_in;
      flush_rec.y_total       = y_total_in;
      flush_rec.count         = count_in;
      flush_rec.end_of_groups = 1'b1;
      if (req_last && !a_open) begin
         close_rec.end_of_groups = 1'b1;
      end

      grp_push.first  = (accept && closes) || flush;
      grp_push.second = accept && closes && flush;
      rec_first       = (accept && closes) ? close_rec : flush_rec;
      rec_second      = flush_rec;
      open_in         = a_open && !flush;

      view_min_in = view_min_ff;
      view_max_in = view_max_ff;
      zoom_in     = zoom_ff;
      if (csr_we) begin
         unique case (csr_index)
            mcpg_pkg::CSR_VIEW_MIN:   view_min_in = csr_wdata;
            mcpg_pkg::CSR_VIEW_MAX:   view_max_in = csr_wdata;
            mcpg_pkg::CSR_ZOOM_LEVEL: zoom_in     = csr_wdata[mcpg_pkg::ZOOM_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_min_ff <= '0;
         view_max_ff <= '1;
         zoom_ff     <= '0;
         open_ff     <= 1'b0;
      end else begin
         view_min_ff <= view_min_in;
         view_max_ff <= view_max_in;
         zoom_ff     <= zoom_in;
         open_ff     <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_end_ff <= cell_end_in;
      x_total_ff  <= x_total_in;
      y_total_ff  <= y_total_in;
      count_ff    <= count_in;
   end

endmodule

// ===== sv/mcpg_queue.sv =====
module mcpg_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  mcpg_pkg::grp_push_type grp_push,
   input  mcpg_pkg::grp_rec_type  rec_first,
   input  mcpg_pkg::grp_rec_type  rec_second,
   input  logic                   que_pop,
   output mcpg_pkg::que_stat_type que_stat,
   output mcpg_pkg::grp_rec_type  que_head
);

   mcpg_pkg::grp_rec_type           slot_ff [mcpg_pkg::QUEUE_DEPTH];
   logic [mcpg_pkg::QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [mcpg_pkg::QPTR_WIDTH-1:0] wr_next;
   logic [mcpg_pkg::QCNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                            pop_ok;

   always_comb begin
      pop_ok  = que_pop && (cnt_ff != '0);
      wr_next = wr_ptr_ff + mcpg_pkg::QPTR_WIDTH'(1);
      cnt_in  = cnt_ff + mcpg_pkg::QCNT_WIDTH'(grp_push.first)
              + mcpg_pkg::QCNT_WIDTH'(grp_push.second) - mcpg_pkg::QCNT_WIDTH'(pop_ok);
      wr_ptr_in = wr_ptr_ff + mcpg_pkg::QPTR_WIDTH'(grp_push.first)
                + mcpg_pkg::QPTR_WIDTH'(grp_push.second);
      rd_ptr_in = rd_ptr_ff + mcpg_pkg::QPTR_WIDTH'(pop_ok);

      que_stat.has_item = cnt_ff != '0;
      que_stat.has_room = cnt_ff <= mcpg_pkg::QCNT_WIDTH'(mcpg_pkg::QUEUE_DEPTH - 2);
      que_head          = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (grp_push.first) begin
         slot_ff[wr_ptr_ff] <= rec_first;
      end
      if (grp_push.second) begin
         slot_ff[wr_next] <= rec_second;
      end
   end

endmodule

// ===== sv/mcpg_back.sv =====
module mcpg_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mcpg_pkg::que_stat_type               que_stat,
   input  mcpg_pkg::grp_rec_type                que_head,
   output logic                                 que_pop,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [mcpg_pkg::CODE_WIDTH-1:0]      rsp_group_code,
   output logic [mcpg_pkg::COUNT_WIDTH-1:0]     rsp_point_count,
   output logic                                 rsp_saturated,
   output logic                                 rsp_end_of_groups
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

   state_type                        state_ff, state_in;
   logic [mcpg_pkg::STEP_WIDTH-1:0]  step_ff, step_in;
   logic [mcpg_pkg::SUM_WIDTH-1:0]   xq_ff, xq_in, yq_ff, yq_in;
   logic [mcpg_pkg::COUNT_WIDTH-1:0] xr_ff, xr_in, yr_ff, yr_in;
   logic [mcpg_pkg::COUNT_WIDTH-1:0] div_ff, div_in;
   logic                             eog_ff, eog_in;
   logic                             out_valid_ff, out_valid_in;
   logic [mcpg_pkg::CODE_WIDTH-1:0]  out_code_ff, out_code_in;
   logic [mcpg_pkg::COUNT_WIDTH-1:0] out_count_ff, out_count_in;
   logic                             out_sat_ff, out_sat_in;
   logic                             out_eog_ff, out_eog_in;

   logic [mcpg_pkg::COUNT_WIDTH:0]   x_sh, y_sh, x_dif, y_dif, div_ext;
   logic                             x_ge, y_ge, out_take;

   always_comb begin
      // restoring division, one quotient bit per cycle for both coordinates
      div_ext = {1'b0, div_ff};
      x_sh    = {xr_ff, xq_ff[mcpg_pkg::SUM_WIDTH-1]};
      y_sh    = {yr_ff, yq_ff[mcpg_pkg::SUM_WIDTH-1]};
      x_ge    = x_sh >= div_ext;
      y_ge    = y_sh >= div_ext;
      x_dif   = x_sh - div_ext;
      y_dif   = y_sh - div_ext;

      que_pop  = (state_ff == ST_IDLE) && que_stat.has_item;
      out_take = (state_ff == ST_HOLD) && (!out_valid_ff || rsp_pop);

      state_in = state_ff;
      step_in  = step_ff;
      xq_in    = xq_ff;
      yq_in    = yq_ff;
      xr_in    = xr_ff;
      yr_in    = yr_ff;
      div_in   = div_ff;
      eog_in   = eog_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (que_stat.has_item) begin
               xq_in    = que_head.x_total;
               yq_in    = que_head.y_total;
               xr_in    = '0;
               yr_in    = '0;
               div_in   = que_head.count;
               eog_in   = que_head.end_of_groups;
               step_in  = mcpg_pkg::STEP_WIDTH'(mcpg_pkg::SUM_WIDTH - 1);
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            xq_in = {xq_ff[mcpg_pkg::SUM_WIDTH-2:0], x_ge};
            yq_in = {yq_ff[mcpg_pkg::SUM_WIDTH-2:0], y_ge};
            xr_in = x_ge ? x_dif[mcpg_pkg::COUNT_WIDTH-1:0] : x_sh[mcpg_pkg::COUNT_WIDTH-1:0];
            yr_in = y_ge ? y_dif[mcpg_pkg::COUNT_WIDTH-1:0] : y_sh[mcpg_pkg::COUNT_WIDTH-1:0];
            if (step_ff == '0) begin
               state_in = ST_HOLD;
            end else begin
               step_in = step_ff - mcpg_pkg::STEP_WIDTH'(1);
            end
         end
         ST_HOLD: begin
            if (out_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_code_in  = out_code_ff;
      out_count_in = out_count_ff;
      out_sat_in   = out_sat_ff;
      out_eog_in   = out_eog_ff;
      if (out_take) begin
         out_valid_in = 1'b1;
         out_code_in  = mcpg_pkg::interleave(xq_ff[mcpg_pkg::COORD_WIDTH-1:0],
                                             yq_ff[mcpg_pkg::COORD_WIDTH-1:0]);
         out_count_in = div_ff;
         out_sat_in   = div_ff == mcpg_pkg::COUNT_MAX;
         out_eog_in   = eog_ff;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
         xq_ff        <= xq_in;
         yq_ff        <= yq_in;
         xr_ff        <= xr_in;
         yr_ff        <= yr_in;
         div_ff       <= div_in;
         eog_ff       <= eog_in;
         out_code_ff  <= out_code_in;
         out_count_ff <= out_count_in;
         out_sat_ff   <= out_sat_in;
         out_eog_ff   <= out_eog_in;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_group_code    = out_code_ff;
   assign rsp_point_count   = out_count_ff;
   assign rsp_saturated     = out_sat_ff;
   assign rsp_end_of_groups = out_eog_ff;

endmodule

// ===== sv/morton_cell_point_grouper_unit.sv =====
// Groups an ascending stream of 64-bit Morton codes into grid cells and
// returns one word per group: the Morton code of the mean point, its count,
// a saturation flag and an end-of-groups flag on the stream's final group.
// Input side is a queue: drive req_code/req_last with req_push while
// req_full is low. Result side is a queue: the oldest group is on rsp_*
// while rsp_empty is low; pulse rsp_pop to take it.
// csr_we/csr_index/csr_wdata write view_min (0), view_max (1), zoom_level (2)
// while the block is idle.
// Points are classified at one per cycle; a closed group costs nothing on
// the input side until the four-entry group queue fills (req_full rises when
// fewer than two entries are free).
// Each group then passes through the back end: it is taken from the
// queue, 56 restoring divider steps form both means, and the output
// register is loaded; the next group is taken only after that load.
// When the result side stalls, the finished group waits in the output
// register, the divider holds, the queue fills and req_full rises.
// Synchronous reset clears the registers to their defaults, closes any
// open group and empties both queues.
`include "morton_cell_point_grouper_unit_assert.svh"

module morton_cell_point_grouper_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [mcpg_pkg::CODE_WIDTH-1:0]      req_code,
   input  logic                                 req_last,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [mcpg_pkg::CODE_WIDTH-1:0]      rsp_group_code,
   output logic [mcpg_pkg::COUNT_WIDTH-1:0]     rsp_point_count,
   output logic                                 rsp_saturated,
   output logic                                 rsp_end_of_groups,
   input  logic                                 csr_we,
   input  logic [mcpg_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mcpg_pkg::CODE_WIDTH-1:0]      csr_wdata
);

   mcpg_pkg::que_stat_type que_stat;
   mcpg_pkg::grp_push_type grp_push;
   mcpg_pkg::grp_rec_type  rec_first, rec_second, que_head;
   logic                   que_pop;

   mcpg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_code   (req_code),
      .req_last   (req_last),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .que_stat   (que_stat),
      .grp_push   (grp_push),
      .rec_first  (rec_first),
      .rec_second (rec_second)
   );

   mcpg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .grp_push   (grp_push),
      .rec_first  (rec_first),
      .rec_second (rec_second),
      .que_pop    (que_pop),
      .que_stat   (que_stat),
      .que_head   (que_head)
   );

   mcpg_back u_back (
      .clock             (clock),
      .reset             (reset),
      .que_stat          (que_stat),
      .que_head          (que_head),
      .que_pop           (que_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_group_code    (rsp_group_code),
      .rsp_point_count   (rsp_point_count),
      .rsp_saturated     (rsp_saturated),
      .rsp_end_of_groups (rsp_end_of_groups)
   );

   `MCPG_ASSERT_IMP(a_count_nonzero, clock, reset, !rsp_empty, rsp_point_count != '0, "group with zero count")
   `MCPG_ASSERT_IMP(a_sat_flag, clock, reset, !rsp_empty, rsp_saturated == (rsp_point_count == mcpg_pkg::COUNT_MAX), "saturation flag mismatch")
   `MCPG_ASSERT_IMP(a_full_has_item, clock, reset, req_full, que_stat.has_item, "input stalled with empty group queue")
   `MCPG_ASSERT_NXT(a_queue_keeps, clock, reset, que_stat.has_item && !que_pop, que_stat.has_item, "group queue lost an entry")

endmodule

// ===== verif/morton_cell_point_grouper_unit_tb.sv =====
`timescale 1ns / 100ps

module morton_cell_point_grouper_unit_tb;

   localparam int unsigned CODE_WIDTH      = mcpg_pkg::CODE_WIDTH;
   localparam int unsigned COORD_WIDTH     = mcpg_pkg::COORD_WIDTH;
   localparam int unsigned COUNT_WIDTH     = mcpg_pkg::COUNT_WIDTH;
   localparam int unsigned SUM_WIDTH       = mcpg_pkg::SUM_WIDTH;
   localparam int unsigned ZOOM_WIDTH      = mcpg_pkg::ZOOM_WIDTH;
   localparam int unsigned CSR_INDEX_WIDTH = mcpg_pkg::CSR_INDEX_WIDTH;
   localparam int unsigned CELL_LOG2_BASE  = mcpg_pkg::CELL_LOG2_BASE;

   localparam int ITEM_GOAL    = 750;
   localparam int DRAIN_CYCLES = 80;
   localparam int STALL_LIMIT  = 4000;

   typedef struct packed {
      logic [CODE_WIDTH-1:0]  code;
      logic [COUNT_WIDTH-1:0] count;
      logic                   sat;
      logic                   eog;
   } grp_word_type;

   typedef struct packed {
      bit                    is_cfg;
      bit                    last;
      bit                    typed;
      logic [ZOOM_WIDTH-1:0] zoom;
      logic [CODE_WIDTH-1:0] a;
      logic [CODE_WIDTH-1:0] b;
      grp_word_type          want;
   } dir_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic [CODE_WIDTH-1:0]      req_code = '0;
   logic                       req_last = 1'b0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic [CODE_WIDTH-1:0]      rsp_group_code;
   logic [COUNT_WIDTH-1:0]     rsp_point_count;
   logic                       rsp_saturated;
   logic                       rsp_end_of_groups;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = mcpg_pkg::CSR_VIEW_MIN;
   logic [CODE_WIDTH-1:0]      csr_wdata = '0;

   morton_cell_point_grouper_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_code          (req_code),
      .req_last          (req_last),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_group_code    (rsp_group_code),
      .rsp_point_count   (rsp_point_count),
      .rsp_saturated     (rsp_saturated),
      .rsp_end_of_groups (rsp_end_of_groups),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow registers and group state of the grouper
   logic [CODE_WIDTH-1:0]  view_lo = '0;
   logic [CODE_WIDTH-1:0]  view_hi = '1;
   logic [ZOOM_WIDTH-1:0]  zoom_sh = '0;
   bit                     grp_open = 1'b0;
   logic [CODE_WIDTH:0]    grp_cell_end = '0;
   logic [SUM_WIDTH-1:0]   grp_xsum = '0;
   logic [SUM_WIDTH-1:0]   grp_ysum = '0;
   logic [COUNT_WIDTH-1:0] grp_cnt = '0;

   grp_word_type grp_expect[$];
   grp_word_type step_words[$];
   bit           step_used;
   dir_row_type  dir_rows[$];

   int  errors = 0;
   int  words_seen = 0;
   int  points_sent = 0;
   int  points_used = 0;
   int  cfg_phases = 0;
   bit  calm = 1'b0;
   int  pop_hold = 0;
   int  quiet = 0;
   grp_word_type mon_want;

   function automatic logic [COORD_WIDTH-1:0] axis_of(input logic [CODE_WIDTH-1:0] c,
                                                      input bit is_y);
      logic [COORD_WIDTH-1:0] v;
      for (int i = 0; i < COORD_WIDTH; i++) begin
         v[i] = c[2*i + (is_y ? 1 : 0)];
      end
      return v;
   endfunction

   function automatic logic [CODE_WIDTH-1:0] zip_xy(input logic [COORD_WIDTH-1:0] x,
                                                    input logic [COORD_WIDTH-1:0] y);
      logic [CODE_WIDTH-1:0] c;
      for (int i = 0; i < COORD_WIDTH; i++) begin
         c[2*i]   = x[i];
         c[2*i+1] = y[i];
      end
      return c;
   endfunction

   function automatic bit in_view_rect(input logic [CODE_WIDTH-1:0] c);
      return axis_of(c, 0) >= axis_of(view_lo, 0) && axis_of(c, 0) <= axis_of(view_hi, 0) &&
             axis_of(c, 1) >= axis_of(view_lo, 1) && axis_of(c, 1) <= axis_of(view_hi, 1);
   endfunction

   function automatic void open_grp(input logic [CODE_WIDTH-1:0] c);
      int                    cl;
      logic [CODE_WIDTH-1:0] base;
      cl = int'(CELL_LOG2_BASE) - int'(zoom_sh);
      if (cl < 0) begin
         cl = 0;
      end
      base         = c & ({CODE_WIDTH{1'b1}} << (2 * cl));
      grp_cell_end = {1'b0, base} + ((CODE_WIDTH+1)'(1) << (2 * cl));
      grp_open     = 1'b1;
      grp_xsum     = SUM_WIDTH'(axis_of(c, 0));
      grp_ysum     = SUM_WIDTH'(axis_of(c, 1));
      grp_cnt      = 1;
   endfunction

   function automatic grp_word_type close_grp();
      grp_word_type         w;
      logic [SUM_WIDTH-1:0] div;
      logic [SUM_WIDTH-1:0] mx;
      logic [SUM_WIDTH-1:0] my;
      div          = (grp_cnt == 0) ? SUM_WIDTH'(1) : SUM_WIDTH'(grp_cnt);
      mx           = grp_xsum / div;
      my           = grp_ysum / div;
      w.code       = zip_xy(mx[COORD_WIDTH-1:0], my[COORD_WIDTH-1:0]);
      w.count      = grp_cnt;
      w.sat        = (grp_cnt == mcpg_pkg::COUNT_MAX);
      w.eog        = 1'b0;
      grp_open     = 1'b0;
      grp_cell_end = '0;
      grp_xsum     = '0;
      grp_ysum     = '0;
      grp_cnt      = '0;
      return w;
   endfunction

   function automatic void predict_point(input logic [CODE_WIDTH-1:0] c, input bit last);
      step_words.delete();
      step_used = (c >= view_lo) && (c <= view_hi);
      if (step_used) begin
         if (grp_open && {1'b0, c} < grp_cell_end) begin
            if (grp_cnt != mcpg_pkg::COUNT_MAX) begin
               grp_xsum = grp_xsum + SUM_WIDTH'(axis_of(c, 0));
               grp_ysum = grp_ysum + SUM_WIDTH'(axis_of(c, 1));
               grp_cnt  = grp_cnt + 1'b1;
            end
         end else begin
            if (grp_open) begin
               step_words.insert(step_words.size(), close_grp());
            end
            if (in_view_rect(c)) begin
               open_grp(c);
            end
         end
      end
      if (last) begin
         if (grp_open) begin
            step_words.insert(step_words.size(), close_grp());
         end
         if (step_words.size() > 0) begin
            step_words[step_words.size()-1].eog = 1'b1;
         end
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic void flag_field(input string what, input logic [CODE_WIDTH-1:0] want,
                                      input logic [CODE_WIDTH-1:0] got);
      errors++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
   endfunction

   function automatic void plan_point(input logic [CODE_WIDTH-1:0] c, input bit last);
      dir_row_type row;
      row      = '0;
      row.a    = c;
      row.last = last;
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   // single-point group flushed by last: the mean is the point itself
   function automatic void plan_point_known(input logic [CODE_WIDTH-1:0] c,
                                            input logic [CODE_WIDTH-1:0] gcode);
      dir_row_type row;
      row            = '0;
      row.a          = c;
      row.last       = 1'b1;
      row.typed      = 1'b1;
      row.want.code  = gcode;
      row.want.count = 1;
      row.want.eog   = 1'b1;
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   function automatic void plan_view(input logic [CODE_WIDTH-1:0] vmin,
                                     input logic [CODE_WIDTH-1:0] vmax,
                                     input logic [ZOOM_WIDTH-1:0] zm);
      dir_row_type row;
      row        = '0;
      row.is_cfg = 1'b1;
      row.a      = vmin;
      row.b      = vmax;
      row.zoom   = zm;
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   task automatic settle();
      req_push <= 1'b0;
      while (grp_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input logic [CODE_WIDTH-1:0] vmin,
                               input logic [CODE_WIDTH-1:0] vmax,
                               input logic [ZOOM_WIDTH-1:0] zm);
      logic [CODE_WIDTH-1:0] junk;
      settle();
      junk      = {$urandom, $urandom};
      csr_we    <= 1'b1;
      csr_index <= mcpg_pkg::CSR_VIEW_MIN;
      csr_wdata <= vmin;
      @(posedge clock);
      csr_index <= mcpg_pkg::CSR_VIEW_MAX;
      csr_wdata <= vmax;
      @(posedge clock);
      csr_index <= mcpg_pkg::CSR_ZOOM_LEVEL;
      csr_wdata <= {junk[CODE_WIDTH-1:ZOOM_WIDTH], zm};
      @(posedge clock);
      csr_we    <= 1'b0;
      view_lo = vmin;
      view_hi = vmax;
      zoom_sh = zm;
      cfg_phases++;
   endtask

   task automatic send_point(input logic [CODE_WIDTH-1:0] c, input bit last, input bit typed,
                             input grp_word_type want);
      int gap;
      req_push <= 1'b1;
      req_code <= c;
      req_last <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_point(c, last);
      if (typed) begin
         grp_expect.insert(grp_expect.size(), want);
      end else begin
         foreach (step_words[i]) grp_expect.insert(grp_expect.size(), step_words[i]);
      end
      points_sent++;
      if (step_used) begin
         points_used++;
      end
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic run_random_phase();
      logic [CODE_WIDTH-1:0]  pts[$];
      logic [COORD_WIDTH-1:0] ox, oy, x0, y0, x1, y1, mask;
      logic [CODE_WIDTH-1:0]  vmin, vmax;
      grp_word_type           none;
      int                     zm, cl, spread, n, kind, pick;
      none = '0;
      kind = $urandom_range(0, 9);
      zm   = $urandom_range(0, 31);
      cl   = int'(CELL_LOG2_BASE) - zm;
      if (cl < 0) begin
         cl = 0;
      end
      spread = cl + $urandom_range(0, 3);
      mask   = (spread >= COORD_WIDTH) ? '1 : (COORD_WIDTH'(1) << spread) - 1'b1;
      ox = $urandom;
      oy = $urandom;
      x0 = ox + ($urandom & (mask >> 2));
      y0 = oy + ($urandom & (mask >> 2));
      x1 = x0 + ($urandom & (mask >> 1));
      y1 = y0 + ($urandom & (mask >> 1));
      if (x1 < x0) begin
         x1 = '1;
      end
      if (y1 < y0) begin
         y1 = '1;
      end
      vmin = zip_xy(x0, y0);
      vmax = zip_xy(x1, y1);
      if (kind == 0) begin
         vmin = '0;
         vmax = '1;
      end else if (kind == 1) begin
         pick = $urandom_range(0, 3);
         unique case (pick)
            0: begin
               // empty viewport
               vmin = zip_xy(x1, y1) + 1'b1;
               vmax = zip_xy(x0, y0);
            end
            1: begin
               vmin = '1;
               vmax = '1;
            end
            2: begin
               vmin = '0;
               vmax = '0;
            end
            default: begin
               vmin = '0;
               vmax = '1;
               zm   = ($urandom_range(0, 1) == 0) ? 0 : 31;
            end
         endcase
      end
      program_regs(vmin, vmax, ZOOM_WIDTH'(zm));
      calm = ($urandom_range(0, 4) == 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 24);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 15);
         if (pick == 0) begin
            pts.insert(pts.size(), '0);
         end else if (pick == 1) begin
            pts.insert(pts.size(), '1);
         end else if (kind == 0 && pick < 9) begin
            pts.insert(pts.size(), {$urandom, $urandom});
         end else begin
            pts.insert(pts.size(), zip_xy(ox + ($urandom & mask), oy + ($urandom & mask)));
         end
      end
      pts.sort();
      // out-of-order noise
      if ($urandom_range(0, 4) == 0) begin
         pts[$urandom_range(0, n - 1)] = {$urandom, $urandom};
      end
      for (int i = 0; i < n; i++) begin
         send_point(pts[i], (i == n - 1) || ($urandom_range(0, 39) == 0), 1'b0, none);
      end
   endtask

   // result side: random stalls with calm stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop  <= 1'b0;
         pop_hold <= 0;
      end else if (pop_hold != 0) begin
         rsp_pop  <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else begin
         rsp_pop <= 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) begin
            pop_hold <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         words_seen++;
         if (grp_expect.size() == 0) begin
            errors++;
            $display("%0t: unexpected group word: expected nothing, got code %h count %0d",
                     $time, rsp_group_code, rsp_point_count);
         end else begin
            mon_want = grp_expect.pop_front();
            if (rsp_group_code !== mon_want.code) begin
               flag_field("group_code", mon_want.code, rsp_group_code);
            end
            if (rsp_point_count !== mon_want.count) begin
               flag_field("point_count", CODE_WIDTH'(mon_want.count), CODE_WIDTH'(rsp_point_count));
            end
            if (rsp_saturated !== mon_want.sat) begin
               flag_field("saturated", CODE_WIDTH'(mon_want.sat), CODE_WIDTH'(rsp_saturated));
            end
            if (rsp_end_of_groups !== mon_want.eog) begin
               flag_field("end_of_groups", CODE_WIDTH'(mon_want.eog),
                          CODE_WIDTH'(rsp_end_of_groups));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet <= 0;
      end else if (quiet >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles, %0d group words outstanding",
                  $time, quiet, grp_expect.size());
         $display("tb: failure");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      // reset defaults: full code window, zoom 0
      plan_point_known('0, '0);
      plan_point_known('1, '1);
      plan_point(64'd5, 1'b0);
      plan_point(64'd6, 1'b0);
      plan_point(64'd7, 1'b1);
      // closes one cell and opens the next with last set
      plan_point(64'h03FF_FFFF_FFFF_FFFF, 1'b0);
      plan_point(64'h0400_0000_0000_0000, 1'b1);
      // code below the open cell joins
      plan_point(64'h1000_0000_0000_0000, 1'b0);
      plan_point(64'd3, 1'b0);
      plan_point(64'h1000_0000_0000_0001, 1'b1);
      // zoom deeper than the grid: one code per cell
      plan_view('0, '1, 5'd31);
      plan_point_known(64'd10, 64'd10);
      plan_point(64'd20, 1'b0);
      plan_point(64'd20, 1'b0);
      plan_point(64'd21, 1'b0);
      plan_point(64'd22, 1'b1);
      plan_view(zip_xy(32'd16, 32'd16), zip_xy(32'd47, 32'd47), 5'd28);
      plan_point(zip_xy(32'd0, 32'd0), 1'b1);
      plan_point(zip_xy(32'd50, 32'd16), 1'b0);
      plan_point(zip_xy(32'd20, 32'd20), 1'b0);
      plan_point(zip_xy(32'd60, 32'd60), 1'b1);
      plan_point(zip_xy(32'd30, 32'd30), 1'b1);
      // empty viewport
      plan_view(zip_xy(32'd47, 32'd47), zip_xy(32'd16, 32'd16), 5'd5);
      plan_point(zip_xy(32'd20, 32'd20), 1'b0);
      plan_point(zip_xy(32'd30, 32'd30), 1'b1);
      plan_view('1, '1, 5'd0);
      plan_point(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
      plan_point_known('1, '1);
      plan_view('0, '1, 5'd30);
      plan_point(64'd1, 1'b0);
      plan_point(64'd2, 1'b1);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         if (dir_rows[r].is_cfg) begin
            program_regs(dir_rows[r].a, dir_rows[r].b, dir_rows[r].zoom);
         end else begin
            send_point(dir_rows[r].a, dir_rows[r].last, dir_rows[r].typed, dir_rows[r].want);
         end
      end

      while (points_sent < ITEM_GOAL) begin
         run_random_phase();
      end

      settle();
      $display("tb: %0d points sent (%0d inside the code window), %0d group words checked",
               points_sent, points_used, words_seen);
      $display("tb: %0d register settings, %0d mismatches", cfg_phases, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
